// File: rtl/tlbpt_pkg.sv
// Shared types and constants for the TLB and page table translator.
// Used by tlbpt_tlb, tlb_page_table_translator and the bench; depends on nothing.
package tlbpt_pkg;

  localparam int TLB_ENTRIES  = 16;
  localparam int PAGE_COUNT   = 1024;
  localparam int FRAME_COUNT  = 256;
  localparam int OFFSET_WIDTH = 10;

  localparam int ADDR_W    = 20;
  localparam int PHYS_W    = 18;
  localparam int PAGE_W    = $clog2(PAGE_COUNT);
  localparam int FRAME_W   = $clog2(FRAME_COUNT);
  localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
  localparam int STAMP_W   = 32;
  localparam int AGE_W     = 16;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
  localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAME_COUNT - 1);
  localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_EVR,
    S_EV,
    S_FIN
  } state_e;

  // One page table entry: resident flag and frame.
  typedef struct packed {
    logic               resident;
    logic [FRAME_W-1:0] frame;
  } pt_entry_t;

  // One frame owner entry: the page held by the frame and its last access stamp.
  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } own_entry_t;

  // TLB update commands from the sequencer.
  typedef struct packed {
    logic               refill;
    logic [PAGE_W-1:0]  refill_page;
    logic [FRAME_W-1:0] refill_frame;
    logic               inval;
    logic [PAGE_W-1:0]  inval_page;
  } tlb_ctrl_t;

endpackage

// File: rtl/tlbpt_tlb.sv
// Fully associative TLB with first-in first-out refill and invalidation by page.
// Depends on tlbpt_pkg.
module tlbpt_tlb (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tlbpt_pkg::PAGE_W-1:0]  lookup_page_i,
  output logic                       hit_o,
  output logic [tlbpt_pkg::FRAME_W-1:0] hit_frame_o,
  input  tlbpt_pkg::tlb_ctrl_t       ctrl_i
);
  import tlbpt_pkg::*;

  logic [TLB_ENTRIES-1:0] valid_q;
  logic [PAGE_W-1:0]      tag_q   [TLB_ENTRIES];
  logic [FRAME_W-1:0]     frame_q [TLB_ENTRIES];
  logic [TLB_IDX_W-1:0]   fill_q;

  // Parallel tag compare; the lowest matching entry wins.
  always_comb begin
    hit_o       = 1'b0;
    hit_frame_o = '0;
    for (int t = TLB_ENTRIES - 1; t >= 0; t--) begin
      if (valid_q[t] && tag_q[t] == lookup_page_i) begin
        hit_o       = 1'b1;
        hit_frame_o = frame_q[t];
      end
    end
  end

  // Valid bits and fill pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
    end else begin
      if (ctrl_i.inval) begin
        for (int t = 0; t < TLB_ENTRIES; t++) begin
          if (tag_q[t] == ctrl_i.inval_page) valid_q[t] <= 1'b0;
        end
      end
      if (ctrl_i.refill) begin
        valid_q[fill_q] <= 1'b1;
        fill_q <= (fill_q == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : fill_q + 1'b1;
      end
    end
  end

  // Tag and frame payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.refill) begin
      tag_q[fill_q]   <= ctrl_i.refill_page;
      frame_q[fill_q] <= ctrl_i.refill_frame;
    end
  end

endmodule

// File: rtl/tlb_page_table_translator.sv
// Address translator with TLB, demand-paged page table and frame replacement.
// Depends on tlbpt_pkg and tlbpt_tlb.

// Translates one word at a time. After reset the block clears its page table and frame
// owner memories before it accepts the first word.
// On a TLB hit or a resident page the word goes from the lookup state to the finish state,
// which loads the result register. A fault with a free frame or under FIFO replacement
// first passes through the eviction read and eviction states; under LRU replacement the
// frame owner memory is scanned, one frame a cycle, before those. The block is ready for
// the next word in the cycle after the result register loads.
// The result register lets the next word be accepted while a result still waits.
module tlb_page_table_translator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tlbpt_pkg::ADDR_W-1:0]   virt_addr_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tlbpt_pkg::PHYS_W-1:0]   phys_addr_o,
  output logic                           tlb_hit_o,
  output logic                           page_fault_o
);
  import tlbpt_pkg::*;

  state_e state_q, state_d;

  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               hit_q, hit_d, fault_q, fault_d;
  logic [FRAME_W-1:0] victim_q, victim_d;
  logic [FRAME_W-1:0] next_frame_q, next_frame_d;
  logic               all_used_q, all_used_d;
  logic               policy_q;
  logic [STAMP_W-1:0] now_q, now_d;
  logic [PAGE_W-1:0]  clr_q, clr_d;
  logic [FRAME_W:0]   scan_q, scan_d;
  logic [FRAME_W-1:0] scan_frame_q, scan_frame_d;
  logic               pend_q, pend_d;
  logic               best_found_q, best_found_d;
  logic [AGE_W-1:0]   best_age_q, best_age_d;
  logic [PAGE_W-1:0]  best_page_q, best_page_d;
  logic [FRAME_W-1:0] best_frame_q, best_frame_d;
  logic               out_valid_q;
  logic [PHYS_W-1:0]  out_phys_q;
  logic               out_hit_q, out_fault_q;

  logic [PAGE_W-1:0]  page;
  logic               go;
  logic               tlb_hit;
  logic [FRAME_W-1:0] tlb_frame;
  tlb_ctrl_t          tlb_ctrl;

  // Memories.
  pt_entry_t  pt_mem  [PAGE_COUNT];
  own_entry_t own_mem [FRAME_COUNT];
  pt_entry_t  pt_rdata_q;
  own_entry_t own_rdata_q;
  logic [PAGE_W-1:0]  pt_raddr, pt_waddr;
  logic               pt_we;
  pt_entry_t          pt_wdata;
  logic [FRAME_W-1:0] own_raddr, own_waddr;
  logic               own_we;
  own_entry_t         own_wdata;

  // Age of the scanned entry, saturated.
  logic [STAMP_W-1:0] scan_diff;
  logic [AGE_W-1:0]   scan_age;

  assign page = addr_q[OFFSET_WIDTH +: PAGE_W];
  assign go   = !out_valid_q || !out_stall_i;

  assign scan_diff = now_q - own_rdata_q.stamp;
  assign scan_age  = (scan_diff >= STAMP_W'(AGE_MAX)) ? AGE_MAX : scan_diff[AGE_W-1:0];

  tlbpt_tlb u_tlb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lookup_page_i(page),
    .hit_o        (tlb_hit),
    .hit_frame_o  (tlb_frame),
    .ctrl_i       (tlb_ctrl)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_q == PAGE_LAST) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_LOOK;
      S_LOOK: begin
        if (tlb_hit || pt_rdata_q.resident) state_d = S_FIN;
        else if (!all_used_q || !policy_q) state_d = S_EVR;
        else state_d = S_SCAN;
      end
      S_SCAN: if (scan_q[FRAME_W] && !pend_q) state_d = S_EVR;
      S_EVR:  state_d = S_EV;
      S_EV:   state_d = S_FIN;
      S_FIN:  if (go) state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    addr_d       = addr_q;
    frame_d      = frame_q;
    hit_d        = hit_q;
    fault_d      = fault_q;
    victim_d     = victim_q;
    next_frame_d = next_frame_q;
    all_used_d   = all_used_q;
    now_d        = now_q;
    clr_d        = clr_q;
    scan_d       = scan_q;
    scan_frame_d = scan_frame_q;
    pend_d       = 1'b0;
    best_found_d = best_found_q;
    best_age_d   = best_age_q;
    best_page_d  = best_page_q;
    best_frame_d = best_frame_q;
    pt_raddr     = virt_addr_i[OFFSET_WIDTH +: PAGE_W];
    pt_we        = 1'b0;
    pt_waddr     = page;
    pt_wdata     = '0;
    own_raddr    = victim_q;
    own_we       = 1'b0;
    own_waddr    = frame_q;
    own_wdata    = '0;
    tlb_ctrl     = '0;
    in_stall_o   = 1'b1;

    unique case (state_q)
      S_CLR: begin
        pt_we     = 1'b1;
        pt_waddr  = clr_q;
        own_we    = 1'b1;
        own_waddr = clr_q[FRAME_W-1:0];
        clr_d     = clr_q + 1'b1;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        addr_d     = virt_addr_i;
      end
      S_LOOK: begin
        hit_d   = tlb_hit;
        fault_d = 1'b0;
        if (tlb_hit) begin
          frame_d = tlb_frame;
        end else if (pt_rdata_q.resident) begin
          frame_d = pt_rdata_q.frame;
        end else begin
          fault_d = 1'b1;
          if (!all_used_q || !policy_q) begin
            victim_d = next_frame_q;
            if (next_frame_q == FRAME_LAST) begin
              next_frame_d = '0;
              all_used_d   = 1'b1;
            end else begin
              next_frame_d = next_frame_q + 1'b1;
            end
          end else begin
            scan_d       = '0;
            best_found_d = 1'b0;
          end
        end
      end
      S_SCAN: begin
        // Issue one read a cycle and fold in the data of the previous read.
        own_raddr = scan_q[FRAME_W-1:0];
        if (!scan_q[FRAME_W]) begin
          scan_d       = scan_q + 1'b1;
          scan_frame_d = scan_q[FRAME_W-1:0];
          pend_d       = 1'b1;
        end
        if (pend_q && own_rdata_q.valid &&
            (!best_found_q || scan_age > best_age_q ||
             (scan_age == best_age_q && own_rdata_q.page < best_page_q))) begin
          best_found_d = 1'b1;
          best_age_d   = scan_age;
          best_page_d  = own_rdata_q.page;
          best_frame_d = scan_frame_q;
        end
        if (scan_q[FRAME_W] && !pend_q) begin
          if (best_found_q) begin
            victim_d = best_frame_q;
          end else begin
            victim_d = next_frame_q;
            if (next_frame_q == FRAME_LAST) begin
              next_frame_d = '0;
              all_used_d   = 1'b1;
            end else begin
              next_frame_d = next_frame_q + 1'b1;
            end
          end
        end
      end
      S_EVR: begin
        own_raddr = victim_q;
      end
      S_EV: begin
        // Evict the page that holds the victim frame.
        frame_d = victim_q;
        if (own_rdata_q.valid) begin
          pt_we               = 1'b1;
          pt_waddr            = own_rdata_q.page;
          tlb_ctrl.inval      = 1'b1;
          tlb_ctrl.inval_page = own_rdata_q.page;
        end
      end
      S_FIN: begin
        if (go) begin
          now_d           = now_q + 1'b1;
          own_we          = 1'b1;
          own_waddr       = frame_q;
          own_wdata.valid = 1'b1;
          own_wdata.page  = page;
          own_wdata.stamp = now_q;
          if (fault_q) begin
            pt_we             = 1'b1;
            pt_waddr          = page;
            pt_wdata.resident = 1'b1;
            pt_wdata.frame    = frame_q;
          end
          if (!hit_q) begin
            tlb_ctrl.refill       = 1'b1;
            tlb_ctrl.refill_page  = page;
            tlb_ctrl.refill_frame = frame_q;
          end
        end
      end
      default: ;
    endcase
  end

  // Memory ports.
  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    pt_rdata_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (own_we) own_mem[own_waddr] <= own_wdata;
    own_rdata_q <= own_mem[own_raddr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_q        <= '0;
      next_frame_q <= '0;
      all_used_q   <= 1'b0;
      policy_q     <= 1'b0;
      now_q        <= '0;
      scan_q       <= '0;
      pend_q       <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      next_frame_q <= next_frame_d;
      all_used_q   <= all_used_d;
      now_q        <= now_d;
      scan_q       <= scan_d;
      pend_q       <= pend_d;
      best_found_q <= best_found_d;
      if (cfg_we_i) policy_q <= cfg_wdata_i;
      if (state_q == S_FIN && go) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    frame_q      <= frame_d;
    hit_q        <= hit_d;
    fault_q      <= fault_d;
    victim_q     <= victim_d;
    scan_frame_q <= scan_frame_d;
    best_age_q   <= best_age_d;
    best_page_q  <= best_page_d;
    best_frame_q <= best_frame_d;
    if (state_q == S_FIN && go) begin
      out_phys_q  <= {frame_q, addr_q[OFFSET_WIDTH-1:0]};
      out_hit_q   <= hit_q;
      out_fault_q <= fault_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign phys_addr_o  = out_phys_q;
  assign tlb_hit_o    = out_hit_q;
  assign page_fault_o = out_fault_q;

endmodule

// File: bench/tlb_page_table_translator_checker.sv
// Checker for the TLB and page table translator: watches both channels and the config port.
// Predicts each result word from its own copy of the TLB, page table and ages.
// Depends on tlbpt_pkg.
module tlb_page_table_translator_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic [tlbpt_pkg::ADDR_W-1:0] virt_addr_i,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic [tlbpt_pkg::PHYS_W-1:0] phys_addr_o,
  input  logic                         tlb_hit_o,
  input  logic                         page_fault_o,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlbpt_pkg::*;

  typedef struct {
    logic [PHYS_W-1:0] phys;
    logic              hit;
    logic              fault;
  } xlate_t;

  xlate_t expected_xlates[$];

  // Model state of the translator.
  logic               lru_mode;
  logic               tlb_valid [TLB_ENTRIES];
  logic [PAGE_W-1:0]  tlb_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame [TLB_ENTRIES];
  int                 fill_ptr;
  logic               resident  [PAGE_COUNT];
  logic [FRAME_W-1:0] frame_of  [PAGE_COUNT];
  logic               age_ok    [PAGE_COUNT];
  logic [AGE_W-1:0]   age       [PAGE_COUNT];
  int                 free_frame;
  logic               frames_full;

  function automatic void clear_model();
    lru_mode = 1'b0;
    fill_ptr = 0;
    free_frame = 0;
    frames_full = 1'b0;
    for (int t = 0; t < TLB_ENTRIES; t++) tlb_valid[t] = 1'b0;
    for (int p = 0; p < PAGE_COUNT; p++) begin
      resident[p] = 1'b0;
      frame_of[p] = '0;
      age_ok[p] = 1'b0;
      age[p] = '0;
    end
  endfunction

  function automatic int take_free_frame();
    int f;
    f = free_frame;
    free_frame++;
    if (free_frame >= FRAME_COUNT) begin
      free_frame = 0;
      frames_full = 1'b1;
    end
    return f;
  endfunction

  // Pick the frame for a faulting page: sequential while frames are free or under FIFO,
  // otherwise the oldest resident page, lowest page number on a tie.
  function automatic int pick_frame();
    int best;
    logic found;
    found = 1'b0;
    best = 0;
    if (!frames_full || !lru_mode) return take_free_frame();
    for (int p = 0; p < PAGE_COUNT; p++) begin
      if (resident[p] && age_ok[p] && (!found || age[p] > age[best])) begin
        found = 1'b1;
        best = p;
      end
    end
    if (!found) return take_free_frame();
    return int'(frame_of[best]);
  endfunction

  function automatic xlate_t translate(logic [ADDR_W-1:0] addr);
    xlate_t r;
    int page;
    int frame;
    page = int'(addr[ADDR_W-1:OFFSET_WIDTH]);
    frame = 0;
    r.hit = 1'b0;
    r.fault = 1'b0;
    for (int t = 0; t < TLB_ENTRIES; t++) begin
      if (!r.hit && tlb_valid[t] && tlb_page[t] == PAGE_W'(page)) begin
        r.hit = 1'b1;
        frame = int'(tlb_frame[t]);
      end
    end
    if (!r.hit) begin
      if (resident[page]) begin
        frame = int'(frame_of[page]);
      end else begin
        r.fault = 1'b1;
        frame = pick_frame();
        // Evict whichever page held the frame, from the table and the TLB.
        for (int p = 0; p < PAGE_COUNT; p++) begin
          if (resident[p] && frame_of[p] == FRAME_W'(frame)) begin
            resident[p] = 1'b0;
            age_ok[p] = 1'b0;
            age[p] = '0;
            for (int t = 0; t < TLB_ENTRIES; t++)
              if (tlb_valid[t] && tlb_page[t] == PAGE_W'(p)) tlb_valid[t] = 1'b0;
          end
        end
        resident[page] = 1'b1;
        frame_of[page] = FRAME_W'(frame);
      end
      tlb_valid[fill_ptr] = 1'b1;
      tlb_page[fill_ptr] = PAGE_W'(page);
      tlb_frame[fill_ptr] = FRAME_W'(frame);
      fill_ptr = (fill_ptr + 1) % TLB_ENTRIES;
    end
    // Ages: the accessed page restarts, then all valid ages step up and saturate.
    age_ok[page] = 1'b1;
    age[page] = '0;
    for (int p = 0; p < PAGE_COUNT; p++)
      if (age_ok[p] && age[p] != AGE_MAX) age[p]++;
    r.phys = PHYS_W'((frame << OFFSET_WIDTH) | int'(addr[OFFSET_WIDTH-1:0]));
    return r;
  endfunction

  initial begin
    clear_model();
    fail_count_o = 0;
    pending_o = 0;
  end

  // Sample everything at the clock edge; the stimulus changes only after it.
  always @(posedge clk_i) begin
    xlate_t want;
    if (rst_ni) begin
      if (cfg_we_i) lru_mode <= cfg_wdata_i;
      if (in_valid_i && !in_stall_o) expected_xlates.push_back(translate(virt_addr_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_xlates.size() == 0) begin
          $display("%0t: unexpected word phys=%h hit=%b fault=%b", $time,
                   phys_addr_o, tlb_hit_o, page_fault_o);
          fail_count_o++;
        end else begin
          want = expected_xlates.pop_front();
          if (phys_addr_o !== want.phys) begin
            $display("%0t: phys_addr expected %h actual %h", $time,
                     want.phys, phys_addr_o);
            fail_count_o++;
          end
          if (tlb_hit_o !== want.hit) begin
            $display("%0t: tlb_hit expected %b actual %b", $time, want.hit, tlb_hit_o);
            fail_count_o++;
          end
          if (page_fault_o !== want.fault) begin
            $display("%0t: page_fault expected %b actual %b", $time, want.fault,
                     page_fault_o);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_xlates.size();
    end
  end

endmodule

// File: bench/tlb_page_table_translator_tb.sv
// Top of the translator testbench: clock, reset, stimulus, watchdog and verdict.
// Depends on tlbpt_pkg, tlb_page_table_translator and tlb_page_table_translator_checker.
module tlb_page_table_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int HOT_PAGES      = 24;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ADDR_W-1:0] virt_addr = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic [PHYS_W-1:0] phys_addr;
  logic              tlb_hit;
  logic              page_fault;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;
  logic              send_burst = 1'b0;
  logic              recv_burst = 1'b0;

  tlb_page_table_translator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .virt_addr_i(virt_addr),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .phys_addr_o(phys_addr), .tlb_hit_o(tlb_hit), .page_fault_o(page_fault)
  );

  tlb_page_table_translator_checker checker_inst (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .virt_addr_i(virt_addr),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .phys_addr_o(phys_addr), .tlb_hit_o(tlb_hit), .page_fault_o(page_fault),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hand one address to the block, after a random gap unless in a burst.
  task automatic send_word(logic [ADDR_W-1:0] addr);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    virt_addr <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait for all results and the block's own work, then write the policy.
  task automatic set_policy(logic lru);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lru;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Half the words from a hot set larger than the TLB, the rest spread over all pages.
  task automatic random_run(int count);
    logic [PAGE_W-1:0] page;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) send_burst <= ($urandom_range(0, 3) == 0);
      page = ($urandom_range(0, 1) == 0) ? PAGE_W'($urandom_range(0, HOT_PAGES - 1))
                                         : PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
      send_word({page, OFFSET_WIDTH'($urandom)});
    end
  endtask

  // Result side stalls at random, with stretches of none.
  initial begin
    int gap;
    int n;
    n = 0;
    @(posedge rst_n);
    forever begin
      if (n % 50 == 0) recv_burst <= ($urandom_range(0, 3) == 0);
      n++;
      gap = recv_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog on cycles without any accepted word.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_policy(1'b0);

    // Directed: address extremes, offset extremes, repeats for hits and resident pages.
    send_word('0);
    send_word('1);
    send_word({PAGE_W'(0), {OFFSET_WIDTH{1'b1}}});
    send_word({{PAGE_W{1'b1}}, OFFSET_WIDTH'(0)});
    send_word(20'h55555);
    send_word(20'hAAAAA);
    for (int p = 1; p <= 18; p++) send_word({PAGE_W'(p), OFFSET_WIDTH'(p * 37)});
    send_word({PAGE_W'(1), OFFSET_WIDTH'(5)});

    // FIFO first, then LRU, back to FIFO and LRU once more.
    random_run(330);
    set_policy(1'b1);
    random_run(250);
    set_policy(1'b0);
    random_run(120);
    set_policy(1'b1);
    random_run(225);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tlbpt_pkg.sv
rtl/tlbpt_tlb.sv
rtl/tlb_page_table_translator.sv
bench/tlb_page_table_translator_checker.sv
bench/tlb_page_table_translator_tb.sv
